// ----- src/ospf_ism_pkg.sv -----
// Shared types, constants and codes for the OSPF interface state machine.
package ospf_ism_pkg;

  localparam int unsigned TableDepthDef = 16;

  typedef enum logic [3:0] {
    OP_NONE      = 4'd0,
    OP_UP        = 4'd1,
    OP_WAITTIMER = 4'd2,
    OP_BACKUPSEEN = 4'd3,
    OP_NBRCHANGE = 4'd4,
    OP_LOOPIND   = 4'd5,
    OP_UNLOOPIND = 4'd6,
    OP_DOWN      = 4'd7,
    OP_WRITE_NBR = 4'd8
  } op_e;

  localparam logic [2:0] StDown     = 3'd1;
  localparam logic [2:0] StLoopback = 3'd2;
  localparam logic [2:0] StWaiting  = 3'd3;
  localparam logic [2:0] StPtp      = 3'd4;
  localparam logic [2:0] StDrOther  = 3'd5;
  localparam logic [2:0] StBackup   = 3'd6;
  localparam logic [2:0] StDr       = 3'd7;

  localparam logic [31:0] AddrNone  = 32'd0;
  localparam logic        NbrTwoWay = 1'b1;

  localparam logic [1:0] LSA_NONE = 2'd0;
  localparam logic [1:0] LSA_ORIG = 2'd1;
  localparam logic [1:0] LSA_FLUSH = 2'd2;

  localparam logic [1:0] CFG_IF_TYPE = 2'd0;
  localparam logic [1:0] CFG_OWN_PRI = 2'd1;
  localparam logic [1:0] CFG_OWN_ADDR = 2'd2;

  typedef struct packed {
    logic [3:0]  operation;
    logic [3:0]  slot;
    logic [31:0] nbr_id;
    logic [31:0] nbr_address;
    logic [7:0]  priority_req;
    logic        two_way;
    logic        declares_dr;
    logic        declares_bdr;
    logic        entry_valid;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  iface_state;
    logic [31:0] dr_addr;
    logic [31:0] bdr_addr;
    logic        state_changed;
    logic        adj_ok_request;
    logic [1:0]  network_lsa_action;
  } out_item_t;

  // Classified command from front to back.
  typedef struct packed {
    logic        wr_nbr;
    logic        is_event;
    logic [3:0]  operation;
    logic [7:0]  slot;
    logic        slot_ok;
    logic [31:0] nbr_id;
    logic [31:0] nbr_address;
    logic [7:0]  priority_req;
    logic        two_way;
    logic        declares_dr;
    logic        declares_bdr;
    logic        entry_valid;
  } cmd_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_BDR_SCAN,
    BK_DR_SCAN,
    BK_ROLE,
    BK_OUT
  } bk_state_e;

endpackage

// ----- src/ospf_interface_state_machine_top.sv -----
// Top level of the OSPF interface state machine with DR/BDR election.
//
// Input channel: in_valid_i/in_ready_o with an in_item_t beat. A beat either
// writes one neighbor-table entry (operation 8) or delivers an interface
// event. Every input beat yields exactly one result beat on the output
// channel out_valid_o/out_ready_i, in order.
// A two-entry command queue sits between the front end, which accepts and
// classifies beats, and the back end, which executes them.
// An event that runs the election scans the table once for the BDR and
// once for the DR, with a registered read, plus a role check; a second
// pass repeats that when the role check calls for it.
// The back end handles one command at a time.
// Reset: state Down, DR and BDR zero, every table entry invalid,
// interface type broadcast, own priority 1, own address zero.
// A stalled receiver holds the result beat; the queue then fills and
// in_ready_o drops. Configuration writes are taken at any cycle, but are
// only to be issued while the block is idle.
module ospf_interface_state_machine_top
  import ospf_ism_pkg::*;
#(
  parameter int unsigned TableDepth = TableDepthDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  input  in_item_t    in_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  output out_item_t   out_data_o,
  output logic        out_valid_o,
  input  logic        out_ready_i
);

  cmd_t cmd;
  logic cmd_valid, cmd_ready;

  ospf_ism_front #(.TableDepth(TableDepth)) u_front (
    .clk_i, .rst_ni, .in_data_i, .in_valid_i, .in_ready_o,
    .cmd_o(cmd), .cmd_valid_o(cmd_valid), .cmd_ready_i(cmd_ready)
  );

  ospf_ism_back #(.TableDepth(TableDepth)) u_back (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .cmd_i(cmd), .cmd_valid_i(cmd_valid), .cmd_ready_o(cmd_ready),
    .out_data_o, .out_valid_o, .out_ready_i
  );

endmodule

// ----- src/ospf_ism_front.sv -----
// Front end: accept input beats, classify them, and queue commands.
module ospf_ism_front
  import ospf_ism_pkg::*;
#(
  parameter int unsigned TableDepth = TableDepthDef
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  in_item_t in_data_i,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  output cmd_t     cmd_o,
  output logic     cmd_valid_o,
  input  logic     cmd_ready_i
);

  localparam int unsigned QDepth = 2;

  cmd_t       q_mem [QDepth];
  logic [1:0] cnt_q, cnt_d;
  logic       wp_q, rp_q;
  cmd_t       cmd_new;
  logic       push, pop;

  always_comb begin
    cmd_new = '0;
    cmd_new.wr_nbr       = (in_data_i.operation == OP_WRITE_NBR);
    cmd_new.is_event     = (in_data_i.operation >= OP_UP) && (in_data_i.operation <= OP_DOWN);
    cmd_new.operation    = in_data_i.operation;
    cmd_new.slot         = {4'd0, in_data_i.slot};
    cmd_new.slot_ok      = (32'(in_data_i.slot) < TableDepth);
    cmd_new.nbr_id       = in_data_i.nbr_id;
    cmd_new.nbr_address  = in_data_i.nbr_address;
    cmd_new.priority_req = in_data_i.priority_req;
    cmd_new.two_way      = in_data_i.two_way;
    cmd_new.declares_dr  = in_data_i.declares_dr;
    cmd_new.declares_bdr = in_data_i.declares_bdr;
    cmd_new.entry_valid  = in_data_i.entry_valid;
  end

  assign in_ready_o  = (cnt_q != 2'(QDepth));
  assign push        = in_valid_i && in_ready_o;
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign pop         = cmd_valid_o && cmd_ready_i;
  assign cmd_o       = q_mem[rp_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push && !pop) cnt_d = cnt_q + 2'd1;
    else if (pop && !push) cnt_d = cnt_q - 2'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (push) wp_q <= ~wp_q;
      if (pop) rp_q <= ~rp_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) q_mem[wp_q] <= cmd_new;
  end

endmodule

// ----- src/ospf_ism_back.sv -----
// Back end: neighbor table, transition table and sequential DR/BDR election.
module ospf_ism_back
  import ospf_ism_pkg::*;
#(
  parameter int unsigned TableDepth = TableDepthDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  input  cmd_t        cmd_i,
  input  logic        cmd_valid_i,
  output logic        cmd_ready_o,
  output out_item_t   out_data_o,
  output logic        out_valid_o,
  input  logic        out_ready_i
);

  localparam int unsigned IdxW = (TableDepth > 1) ? $clog2(TableDepth) : 1;
  localparam int unsigned CntW = $clog2(TableDepth + 1);

  logic [2:0]  if_type_q;
  logic [7:0]  own_pri_q;
  logic [31:0] own_addr_q;

  logic [31:0] ids_mem [TableDepth];
  logic [31:0] addrs_mem [TableDepth];
  logic [10:0] flags_mem [TableDepth];
  logic [TableDepth-1:0] valid_q;

  bk_state_e   st_q, st_d;
  logic [2:0]  cur_q, cur_d;
  logic [31:0] dr_q, dr_d, bdr_q, bdr_d;
  logic [31:0] old_dr_q, old_dr_d, old_bdr_q, old_bdr_d;
  logic [2:0]  old_st_q, old_st_d;
  logic        pass2_q, pass2_d;
  logic [CntW-1:0] idx_q, idx_d;
  logic        bb_v_q, bb_v_d, ba_v_q, ba_v_d, keep_v_q, keep_v_d;
  logic [7:0]  bb_p_q, bb_p_d, ba_p_q, ba_p_d;
  logic [31:0] bb_id_q, bb_id_d, ba_id_q, ba_id_d;
  logic [31:0] bb_ad_q, bb_ad_d, ba_ad_q, ba_ad_d, keep_ad_q, keep_ad_d;
  out_item_t   res_q, res_d;
  logic        out_v_q, out_v_d;
  logic        cmd_ready;

  // Registered table read of the scanned entry.
  logic [31:0] rd_id_q, rd_ad_q;
  logic [10:0] rd_fl_q;
  logic        rd_v_q, rd_en;
  logic [IdxW-1:0] rd_idx;

  logic        elig, sdr, sbdr, beat_bb, beat_ba;
  logic [2:0]  role, ns;
  logic        run_el, last;

  assign rd_idx = idx_q[IdxW-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_ready && cmd_valid_i && cmd_i.wr_nbr && cmd_i.slot_ok) begin
      ids_mem[cmd_i.slot[IdxW-1:0]]   <= cmd_i.nbr_id;
      addrs_mem[cmd_i.slot[IdxW-1:0]] <= cmd_i.nbr_address;
      flags_mem[cmd_i.slot[IdxW-1:0]] <= {cmd_i.declares_bdr, cmd_i.declares_dr,
                                          cmd_i.two_way, cmd_i.priority_req};
    end
    if (rd_en) begin
      rd_id_q <= ids_mem[rd_idx];
      rd_ad_q <= addrs_mem[rd_idx];
      rd_fl_q <= flags_mem[rd_idx];
    end
  end

  assign rd_en = (idx_q < CntW'(TableDepth));

  assign elig = rd_v_q && (rd_id_q != 32'd0) && (rd_fl_q[7:0] != 8'd0)
             && (rd_fl_q[8] == NbrTwoWay);
  assign sdr  = (rd_ad_q == own_addr_q) ? (dr_q == own_addr_q) : rd_fl_q[9];
  assign sbdr = (rd_ad_q == own_addr_q) ? (bdr_q == own_addr_q) : rd_fl_q[10];
  assign beat_bb = !bb_v_q || (rd_fl_q[7:0] > bb_p_q)
                || ((rd_fl_q[7:0] == bb_p_q) && (rd_id_q > bb_id_q));
  assign beat_ba = !ba_v_q || (rd_fl_q[7:0] > ba_p_q)
                || ((rd_fl_q[7:0] == ba_p_q) && (rd_id_q > ba_id_q));
  assign last = (idx_q == CntW'(TableDepth));

  assign role = (dr_q == own_addr_q) ? StDr
              : (bdr_q == own_addr_q) ? StBackup : StDrOther;

  assign cmd_ready   = (st_q == BK_IDLE) && !out_v_q;
  assign cmd_ready_o = cmd_ready;
  assign out_valid_o = out_v_q;
  assign out_data_o  = res_q;

  always_comb begin
    ns = cur_q;
    run_el = 1'b0;
    unique case (cmd_i.operation)
      OP_DOWN:     ns = StDown;
      OP_LOOPIND:  ns = StLoopback;
      OP_UNLOOPIND: if (cur_q == StLoopback) ns = StDown;
      OP_UP: if (cur_q == StDown) begin
        if (if_type_q >= 3'd2 && if_type_q <= 3'd4) ns = StPtp;
        else if (own_pri_q == 8'd0) ns = StDrOther;
        else ns = StWaiting;
      end
      OP_WAITTIMER, OP_BACKUPSEEN: run_el = (cur_q == StWaiting);
      OP_NBRCHANGE: run_el = (cur_q == StDrOther) || (cur_q == StBackup)
                          || (cur_q == StDr);
      default: ns = cur_q;
    endcase
  end

  function automatic logic [1:0] lsa_f(logic [2:0] o, logic [2:0] n);
    if (o != StDr && n == StDr) return LSA_ORIG;
    if (o == StDr && n != StDr) return LSA_FLUSH;
    return LSA_NONE;
  endfunction

  always_comb begin
    st_d = st_q; cur_d = cur_q; dr_d = dr_q; bdr_d = bdr_q;
    old_dr_d = old_dr_q; old_bdr_d = old_bdr_q; old_st_d = old_st_q;
    pass2_d = pass2_q; idx_d = idx_q;
    bb_v_d = bb_v_q; bb_p_d = bb_p_q; bb_id_d = bb_id_q; bb_ad_d = bb_ad_q;
    ba_v_d = ba_v_q; ba_p_d = ba_p_q; ba_id_d = ba_id_q; ba_ad_d = ba_ad_q;
    keep_v_d = keep_v_q; keep_ad_d = keep_ad_q;
    res_d = res_q; out_v_d = out_v_q;
    if (out_v_q && out_ready_i) out_v_d = 1'b0;
    unique case (st_q)
      BK_IDLE: if (cmd_valid_i && cmd_ready) begin
        res_d = '0;
        if (cmd_i.is_event && run_el) begin
          old_dr_d = dr_q; old_bdr_d = bdr_q; old_st_d = cur_q;
          pass2_d = 1'b0; idx_d = '0;
          bb_v_d = 1'b0; ba_v_d = 1'b0;
          st_d = BK_BDR_SCAN;
        end else begin
          if (cmd_i.is_event) begin
            cur_d = ns;
            res_d.state_changed = (ns != cur_q);
            res_d.network_lsa_action = lsa_f(cur_q, ns);
          end
          res_d.iface_state = cmd_i.is_event ? ns : cur_q;
          res_d.dr_addr = dr_q; res_d.bdr_addr = bdr_q;
          out_v_d = 1'b1;
        end
      end
      BK_BDR_SCAN: begin
        // Read runs one entry ahead of the compare.
        if (idx_q != '0 && elig && !sdr) begin
          if (sbdr && beat_bb) begin
            bb_v_d = 1'b1; bb_p_d = rd_fl_q[7:0]; bb_id_d = rd_id_q; bb_ad_d = rd_ad_q;
          end
          if (beat_ba) begin
            ba_v_d = 1'b1; ba_p_d = rd_fl_q[7:0]; ba_id_d = rd_id_q; ba_ad_d = rd_ad_q;
          end
        end
        idx_d = idx_q + 1'b1;
        if (last) begin
          bdr_d = bb_v_d ? bb_ad_d : (ba_v_d ? ba_ad_d : 32'd0);
          idx_d = '0; bb_v_d = 1'b0; keep_v_d = 1'b0;
          st_d = BK_DR_SCAN;
        end
      end
      BK_DR_SCAN: begin
        if (idx_q != '0 && elig) begin
          if (sdr && beat_bb) begin
            bb_v_d = 1'b1; bb_p_d = rd_fl_q[7:0]; bb_id_d = rd_id_q; bb_ad_d = rd_ad_q;
          end
          if (rd_ad_q == bdr_q) begin
            keep_v_d = 1'b1; keep_ad_d = rd_ad_q;
          end
        end
        idx_d = idx_q + 1'b1;
        if (last) begin
          dr_d = bb_v_d ? bb_ad_d : (keep_v_d ? keep_ad_d : 32'd0);
          st_d = BK_ROLE;
        end
      end
      BK_ROLE: begin
        if (!pass2_q && role != old_st_q
            && !(role == StDrOther && old_st_q < StDrOther)) begin
          pass2_d = 1'b1; idx_d = '0; bb_v_d = 1'b0; ba_v_d = 1'b0;
          st_d = BK_BDR_SCAN;
        end else begin
          cur_d = role;
          st_d = BK_OUT;
        end
      end
      BK_OUT: begin
        res_d.iface_state = cur_q;
        res_d.dr_addr = dr_q; res_d.bdr_addr = bdr_q;
        res_d.state_changed = (cur_q != old_st_q);
        res_d.adj_ok_request = (dr_q != old_dr_q) || (bdr_q != old_bdr_q);
        res_d.network_lsa_action = lsa_f(old_st_q, cur_q);
        out_v_d = 1'b1;
        st_d = BK_IDLE;
      end
      default: st_d = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= BK_IDLE; cur_q <= StDown; dr_q <= AddrNone; bdr_q <= AddrNone;
      out_v_q <= 1'b0; valid_q <= '0; rd_v_q <= 1'b0; idx_q <= '0; pass2_q <= 1'b0;
      if_type_q <= 3'd0; own_pri_q <= 8'd1; own_addr_q <= 32'd0;
    end else begin
      st_q <= st_d; cur_q <= cur_d; dr_q <= dr_d; bdr_q <= bdr_d;
      out_v_q <= out_v_d; idx_q <= idx_d; pass2_q <= pass2_d;
      rd_v_q <= rd_en ? valid_q[rd_idx] : 1'b0;
      if (cmd_ready && cmd_valid_i && cmd_i.wr_nbr && cmd_i.slot_ok)
        valid_q[cmd_i.slot[IdxW-1:0]] <= cmd_i.entry_valid;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_IF_TYPE:  if_type_q <= cfg_data_i[2:0];
          CFG_OWN_PRI:  own_pri_q <= cfg_data_i[7:0];
          CFG_OWN_ADDR: own_addr_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    old_dr_q <= old_dr_d; old_bdr_q <= old_bdr_d; old_st_q <= old_st_d;
    bb_v_q <= bb_v_d; bb_p_q <= bb_p_d; bb_id_q <= bb_id_d; bb_ad_q <= bb_ad_d;
    ba_v_q <= ba_v_d; ba_p_q <= ba_p_d; ba_id_q <= ba_id_d; ba_ad_q <= ba_ad_d;
    keep_v_q <= keep_v_d; keep_ad_q <= keep_ad_d; res_q <= res_d;
  end

endmodule

// ----- src/ospf_ism_checker.sv -----
// Port-level checker for the OSPF interface state machine, bound to the top.
module ospf_ism_checker
  import ospf_ism_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      out_valid_o,
  input logic      out_ready_i,
  input out_item_t out_data_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result beat dropped or changed while stalled");

  a_state_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.iface_state != 3'd0)
    else $error("result shows no interface state");

  a_lsa_dr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.network_lsa_action == LSA_ORIG
      |-> out_data_o.iface_state == StDr && out_data_o.state_changed)
    else $error("originate without entering DR");

  a_lsa_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.network_lsa_action != 2'd3)
    else $error("bad network LSA action");

endmodule

bind ospf_interface_state_machine_top ospf_ism_checker u_chk (
  .clk_i, .rst_ni, .out_valid_o, .out_ready_i, .out_data_o
);
